// File: src/dda_pkg.sv
// Shared types and fixed field widths for the DDA line rasterizer.
// No dependencies; imported by every module of the block.
package dda_pkg;

  // Every coordinate field on the stream ports is six bits wide.
  localparam int FIELD_W     = 6;
  localparam int IN_TDATA_W  = 4 * FIELD_W;
  localparam int OUT_TDATA_W = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic emit;
  } dda_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;      // no steps left on the current line
    logic div_last;  // the current divide step produces the final quotient bit
    logic out_free;  // the output register can take a pixel this cycle
  } dda_sts_t;

endpackage

// File: src/dda_ctrl.sv
// Sequencing state machine of the DDA line rasterizer.
// Depends on dda_pkg for the command and status structs.
module dda_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  dda_pkg::dda_sts_t sts_i,
  output dda_pkg::dda_cmd_t cmd_o
);
  import dda_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_o.load = 1'b1;
          state_nxt  = ST_DIV;
        end
      end
      ST_DIV: begin
        // A zero-length line needs no increments.
        if (sts_i.last) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd_o.div_step = 1'b1;
          if (sts_i.div_last) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.load |=> (state_r == ST_DIV) && !in_tready)
    else $error("load did not start the divide phase");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.emit && sts_i.last) |=> in_tready)
    else $error("block not ready after the final pixel");

  a_idle_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !cmd_o.emit && !cmd_o.div_step)
    else $error("datapath commanded while idle");

endmodule

// File: src/dda_datapath.sv
// Datapath of the DDA line rasterizer: serial divider, accumulators, output register.
// Depends on dda_pkg for field widths and the command and status structs.
module dda_datapath #(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [dda_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  dda_pkg::dda_cmd_t                   cmd_i,
  output dda_pkg::dda_sts_t                   sts_o,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dda_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast
);
  import dda_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int AW = C + F + 1;
  localparam int IW = F + 2;
  localparam int CW = $clog2(F + 1);

  logic [C-1:0] xs, ys, xe, ye;
  logic         x_neg, y_neg, x_major;
  logic [C-1:0] adx, ady, steps, minor;

  logic [AW-1:0] x_acc_r, y_acc_r;
  logic [IW-1:0] x_inc_r, y_inc_r;
  logic [C-1:0]  steps_left_r;
  logic [C-1:0]  divisor_r;
  logic [C:0]    rem_r;
  logic [F-1:0]  quo_r;
  logic [CW-1:0] cnt_r;
  logic          x_neg_r, y_neg_r, x_major_r;

  logic [FIELD_W-1:0] out_x_r, out_y_r;
  logic               out_last_r;
  logic               out_valid_r;

  logic          ge;
  logic [C:0]    diff;
  logic [F:0]    q_full;
  logic [IW-1:0] minor_mag, major_mag, x_mag, y_mag;
  logic [AW-1:0] x_rnd, y_rnd;
  logic          last;

  assign xs = in_tdata[0 +: C];
  assign ys = in_tdata[FIELD_W +: C];
  assign xe = in_tdata[2*FIELD_W +: C];
  assign ye = in_tdata[3*FIELD_W +: C];

  assign x_neg   = xe < xs;
  assign y_neg   = ye < ys;
  assign adx     = x_neg ? xs - xe : xe - xs;
  assign ady     = y_neg ? ys - ye : ye - ys;
  assign x_major = adx >= ady;
  assign steps   = x_major ? adx : ady;
  assign minor   = x_major ? ady : adx;

  // One restoring-division step: the remainder always stays below twice the divisor.
  assign ge     = rem_r >= {1'b0, divisor_r};
  assign diff   = ge ? rem_r - {1'b0, divisor_r} : rem_r;
  assign q_full = {quo_r, ge};

  assign minor_mag = {1'b0, q_full};
  assign major_mag = IW'(1) << F;
  assign x_mag     = x_major_r ? major_mag : minor_mag;
  assign y_mag     = x_major_r ? minor_mag : major_mag;

  assign x_rnd = x_acc_r + (AW'(1) << (F - 1));
  assign y_rnd = y_acc_r + (AW'(1) << (F - 1));
  assign last  = steps_left_r == '0;

  assign sts_o.last     = last;
  assign sts_o.div_last = cnt_r == CW'(F);
  assign sts_o.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      x_acc_r      <= {1'b0, xs, {F{1'b0}}};
      y_acc_r      <= {1'b0, ys, {F{1'b0}}};
      steps_left_r <= steps;
      divisor_r    <= steps;
      rem_r        <= {1'b0, minor};
      quo_r        <= '0;
      cnt_r        <= '0;
      x_neg_r      <= x_neg;
      y_neg_r      <= y_neg;
      x_major_r    <= x_major;
    end
    if (cmd_i.div_step) begin
      rem_r <= {diff[C-1:0], 1'b0};
      quo_r <= {quo_r[F-2:0], ge};
      cnt_r <= cnt_r + CW'(1);
      if (sts_o.div_last) begin
        x_inc_r <= x_neg_r ? -x_mag : x_mag;
        y_inc_r <= y_neg_r ? -y_mag : y_mag;
      end
    end
    if (cmd_i.emit) begin
      out_x_r    <= FIELD_W'(x_rnd[F +: C]);
      out_y_r    <= FIELD_W'(y_rnd[F +: C]);
      out_last_r <= last;
      if (!last) begin
        x_acc_r      <= x_acc_r + {{(AW-IW){x_inc_r[IW-1]}}, x_inc_r};
        y_acc_r      <= y_acc_r + {{(AW-IW){y_inc_r[IW-1]}}, y_inc_r};
        steps_left_r <= steps_left_r - C'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TDATA_W-2*FIELD_W){1'b0}}, out_y_r, out_x_r};

endmodule

// File: src/dda_line_rasterizer.sv
// An input transfer starts the serial divider; once it finishes, the first pixel is offered
// through the output register. A zero-length line skips the divide steps.
// A line of S>0 steps then yields one pixel per cycle while the output does not stall.
// Reset (rst_n low at a clock edge) clears the controller state and the output valid flag.
// Depends on dda_pkg, dda_ctrl and dda_datapath.
module dda_line_rasterizer #(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input line segments.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dda_pkg::IN_TDATA_W-1:0]  in_tdata,   // x_start, y_start, x_end, y_end
  // Output pixels.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dda_pkg::OUT_TDATA_W-1:0] out_tdata,  // pixel_x, pixel_y, 4 zero bits
  output logic                            out_tlast   // last_pixel
);
  import dda_pkg::*;

  // The controller takes a segment only when idle. It loads the datapath, which
  // captures the start point into the Q-format accumulators, the step count
  // (the larger of |dx| and |dy|) and the minor-axis delta as the dividend.
  // The major-axis increment is exactly one pixel, so a single restoring
  // divider, one quotient bit per cycle, yields the minor-axis increment.
  // Pixels are then produced one per transfer through a registered output, and
  // the block becomes ready for the next segment as soon as the final pixel
  // sits in that register, even while it is still waiting to be taken.
  dda_cmd_t cmd;
  dda_sts_t sts;

  dda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  dda_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
